/* design/mchq_pkg.sv */
// ----------------------------------------------------------------------------
// mchq_pkg
// Types and constants shared by the monotone convex hull minimum query block.
// ----------------------------------------------------------------------------
package mchq_pkg;

  localparam int XW    = 32;              // point x
  localparam int YW    = 48;              // point y
  localparam int KW    = 32;              // query slope
  localparam int RW    = 64;              // result value
  localparam int VW    = RW + 1;          // unsaturated line value
  localparam int MW    = 33;              // multiplier operand
  localparam int PW    = 2 * MW;          // multiplier product
  localparam int LO_W  = 25;              // low chunk of a y difference
  localparam int HI_W  = YW + 1 - LO_W;   // high chunk of a y difference
  localparam int ACC_W = 84;              // cross product accumulator

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]             operation;
    logic signed [XW-1:0]   line_slope;
    logic signed [YW-1:0]   line_intercept;
    logic signed [KW-1:0]   query_point;
  } req_t;

  typedef struct packed {
    logic signed [RW-1:0]   min_value;
    logic [1:0]             status;
  } res_t;

  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic acc_clr;
    logic acc_shift;
    logic acc_sub;
  } mac_ctl_t;

endpackage

/* design/mchq_ram.sv */
// ----------------------------------------------------------------------------
// mchq_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module mchq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

/* design/mchq_mac.sv */
// ----------------------------------------------------------------------------
// mchq_mac
// Shared signed multiplier with a registered product and a wide accumulator
// that adds or subtracts partial products, shifted or not.
// ----------------------------------------------------------------------------
module mchq_mac (
  input  logic                              clk,
  input  mchq_pkg::mac_ctl_t                ctl,
  input  logic signed [mchq_pkg::MW-1:0]    a,
  input  logic signed [mchq_pkg::MW-1:0]    b,
  output logic signed [mchq_pkg::PW-1:0]    prod,
  output logic signed [mchq_pkg::ACC_W-1:0] acc
);
  import mchq_pkg::*;

  logic signed [PW-1:0]    prod_next;
  logic signed [ACC_W-1:0] term;
  logic signed [ACC_W-1:0] shifted;
  logic signed [ACC_W-1:0] base;
  logic signed [ACC_W-1:0] acc_next;

  assign prod_next = a * b;
  assign term      = {{(ACC_W - PW){prod[PW-1]}}, prod};
  assign shifted   = ctl.acc_shift ? (term <<< LO_W) : term;
  assign base      = ctl.acc_clr ? '0 : acc;
  assign acc_next  = ctl.acc_sub ? (base - shifted) : (base + shifted);

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= prod_next;
    end
    if (ctl.acc_en) begin
      acc <= acc_next;
    end
  end

endmodule

/* design/monotone_convex_hull_min_query.sv */
// ----------------------------------------------------------------------------
// monotone_convex_hull_min_query
// Clear, unused op, empty query: done state, then the result register.
// Insert: per tail point tested, a read, a difference and a shared-multiplier
//   cross product, then pop or write; query: per point evaluated, memory read,
//   then multiply and compare. One item at a time; pops and head moves amortize.
// Reset: head and tail go to zero; point memories are not cleared.
// ----------------------------------------------------------------------------
module monotone_convex_hull_min_query #(
  parameter int DEPTH = 1024
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  mchq_pkg::req_t req,
  output logic           res_valid,
  input  logic           res_stall,
  output mchq_pkg::res_t res
);
  import mchq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_INS_CHK, S_INS_DIFF, S_INS_MUL, S_INS_DEC, S_INS_FIN,
    S_Q_MUL, S_Q_EVAL, S_DONE
  } state_t;

  state_t state;

  logic [CW-1:0]        head;
  logic [CW-1:0]        tail;
  logic [CW-1:0]        t;
  logic [CW-1:0]        cand;
  logic signed [XW-1:0] vx;
  logic signed [YW-1:0] vy;
  logic signed [KW-1:0] k;
  logic signed [XW:0]   dx1;
  logic signed [XW:0]   dx2;
  logic signed [YW:0]   dy1;
  logic signed [YW:0]   dy2;
  logic [2:0]           ph;
  logic signed [VW-1:0] best;
  logic                 first;
  logic signed [RW-1:0] pend_value;
  logic [1:0]           pend_status;

  logic                 ram_we;
  logic                 ram_re;
  logic [AW-1:0]        raddr_a;
  logic [AW-1:0]        raddr_b;
  logic [XW-1:0]        x_a;
  logic [XW-1:0]        x_b;
  logic [YW-1:0]        y_a;
  logic [YW-1:0]        y_b;

  mac_ctl_t                mac_ctl;
  logic signed [MW-1:0]    mul_a;
  logic signed [MW-1:0]    mul_b;
  logic signed [PW-1:0]    prod;
  logic signed [ACC_W-1:0] acc;

  logic [CW-1:0]        t_m1;
  logic [CW-1:0]        t_m2;
  logic [CW-1:0]        cand_nx;
  logic                 can_pop;
  logic                 more;
  logic signed [VW-1:0] nv;
  logic                 take;
  logic signed [VW-1:0] pick;
  logic signed [RW-1:0] pick_sat;
  logic                 cross_le0;

  assign t_m1      = t - 1'b1;
  assign t_m2      = t - 2'd2;
  assign cand_nx   = cand + 1'b1;
  assign can_pop   = {1'b0, t} >= ({1'b0, head} + (CW + 1)'(2));
  assign more      = cand_nx < tail;
  assign nv        = $signed({{(VW - YW){y_a[YW-1]}}, y_a}) - prod[VW-1:0];
  assign take      = first || !(nv > best);
  assign pick      = take ? nv : best;
  assign pick_sat  = (pick[VW-1] != pick[VW-2])
                   ? (pick[VW-1] ? {1'b1, {(RW - 1){1'b0}}} : {1'b0, {(RW - 1){1'b1}}})
                   : pick[RW-1:0];
  assign cross_le0 = acc[ACC_W-1] || (acc == '0);
  assign req_stall = (state != S_IDLE);
  assign ram_we    = (state == S_INS_FIN) && (t != DEPTH_C);

  always_comb begin
    ram_re  = 1'b0;
    raddr_a = t_m1[AW-1:0];
    raddr_b = t_m2[AW-1:0];
    case (state)
      S_IDLE: begin
        if (req_valid && req.operation == OP_QUERY && tail > head) begin
          ram_re  = 1'b1;
          raddr_a = head[AW-1:0];
        end
      end
      S_INS_CHK: begin
        ram_re = can_pop;
      end
      S_Q_EVAL: begin
        if (take && more) begin
          ram_re  = 1'b1;
          raddr_a = cand_nx[AW-1:0];
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    mac_ctl = '0;
    mul_a   = '0;
    mul_b   = '0;
    case (state)
      S_INS_MUL: begin
        mac_ctl.mul_en    = (ph < 3'd4);
        mac_ctl.acc_en    = (ph != 3'd0);
        mac_ctl.acc_clr   = (ph == 3'd1);
        mac_ctl.acc_shift = (ph == 3'd2) || (ph == 3'd4);
        mac_ctl.acc_sub   = (ph >= 3'd3);
        case (ph)
          3'd0: begin
            mul_a = dx1;
            mul_b = $signed({{(MW - LO_W){1'b0}}, dy2[LO_W-1:0]});
          end
          3'd1: begin
            mul_a = dx1;
            mul_b = $signed({{(MW - HI_W){dy2[YW]}}, dy2[YW:LO_W]});
          end
          3'd2: begin
            mul_a = dx2;
            mul_b = $signed({{(MW - LO_W){1'b0}}, dy1[LO_W-1:0]});
          end
          3'd3: begin
            mul_a = dx2;
            mul_b = $signed({{(MW - HI_W){dy1[YW]}}, dy1[YW:LO_W]});
          end
          default: ;
        endcase
      end
      S_Q_MUL: begin
        mac_ctl.mul_en = 1'b1;
        mul_a          = $signed({x_a[XW-1], x_a});
        mul_b          = $signed({{(MW - KW){k[KW-1]}}, k});
      end
      default: ;
    endcase
  end

  mchq_ram #(.WIDTH(XW), .DEPTH(DEPTH)) u_x_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (t[AW-1:0]),
    .wdata   (vx),
    .re      (ram_re),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (x_a),
    .rdata_b (x_b)
  );

  mchq_ram #(.WIDTH(YW), .DEPTH(DEPTH)) u_y_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (t[AW-1:0]),
    .wdata   (vy),
    .re      (ram_re),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (y_a),
    .rdata_b (y_b)
  );

  mchq_mac u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod),
    .acc  (acc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && !res_stall && state != S_DONE) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            pend_value  <= '0;
            pend_status <= (req.operation == OP_QUERY && !(tail > head)) ? ST_EMPTY : ST_OK;
            vx          <= req.line_slope;
            vy          <= req.line_intercept;
            k           <= req.query_point;
            case (req.operation)
              OP_INSERT: begin
                t     <= tail;
                state <= S_INS_CHK;
              end
              OP_QUERY: begin
                if (tail > head) begin
                  cand  <= head;
                  first <= 1'b1;
                  state <= S_Q_MUL;
                end else begin
                  state <= S_DONE;
                end
              end
              OP_CLEAR: begin
                head  <= '0;
                tail  <= '0;
                state <= S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_INS_CHK: begin
          state <= can_pop ? S_INS_DIFF : S_INS_FIN;
        end
        S_INS_DIFF: begin
          dx1   <= $signed({x_a[XW-1], x_a}) - $signed({x_b[XW-1], x_b});
          dy1   <= $signed({y_a[YW-1], y_a}) - $signed({y_b[YW-1], y_b});
          dx2   <= $signed({vx[XW-1], vx}) - $signed({x_a[XW-1], x_a});
          dy2   <= $signed({vy[YW-1], vy}) - $signed({y_a[YW-1], y_a});
          ph    <= 3'd0;
          state <= S_INS_MUL;
        end
        S_INS_MUL: begin
          ph <= ph + 3'd1;
          if (ph == 3'd4) begin
            state <= S_INS_DEC;
          end
        end
        S_INS_DEC: begin
          if (cross_le0) begin
            t     <= t_m1;
            state <= S_INS_CHK;
          end else begin
            state <= S_INS_FIN;
          end
        end
        S_INS_FIN: begin
          if (t == DEPTH_C) begin
            pend_status <= ST_FULL;
          end else begin
            tail <= t + 1'b1;
          end
          state <= S_DONE;
        end
        S_Q_MUL: begin
          state <= S_Q_EVAL;
        end
        S_Q_EVAL: begin
          first <= 1'b0;
          if (take) begin
            best <= nv;
            head <= cand;
          end
          if (take && more) begin
            cand  <= cand_nx;
            state <= S_Q_MUL;
          end else begin
            pend_value <= pick_sat;
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          if (!res_valid || !res_stall) begin
            res_valid     <= 1'b1;
            res.min_value <= pend_value;
            res.status    <= pend_status;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_head_le_tail: assert property (@(posedge clk) disable iff (rst)
    head <= tail)
    else $error("head passed tail");

  a_tail_le_depth: assert property (@(posedge clk) disable iff (rst)
    tail <= DEPTH_C)
    else $error("tail beyond store depth");

  a_res_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == S_DONE)
    else $error("result issued outside done state");

  a_tail_append: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS_FIN && t != DEPTH_C) |=> tail == $past(t) + 1'b1)
    else $error("append did not advance tail");
`endif

endmodule
